[rtl/ctcgd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ctcgd_pkg;

  // Sizing limits of the decoder
  localparam int MAX_CLASSES = 32768;
  localparam int MAX_STEPS   = 1024;

  // Field widths
  localparam int ScoreW = 16;
  localparam int IdW    = 15;
  localparam int SumW   = 27;
  localparam int TallyW = 11;

  // Saturation limits of the column counter and the token tally
  localparam int ColLimit   = ((MAX_CLASSES - 1) < 32767) ? (MAX_CLASSES - 1) : 32767;
  localparam int TallyLimit = (MAX_STEPS < 2047) ? MAX_STEPS : 2047;

  // Command queue between front and back
  localparam int QueueDepth = 4;

  // Divider runs one quotient bit per cycle
  localparam int DivSteps = SumW;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic signed [ScoreW-1:0] SCORE_MIN = 16'sh8000;

  typedef enum logic {
    KIND_TOKEN   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TOKEN,
    BK_DIV,
    BK_SUMMARY
  } back_state_e;

  // One queued command: an optional token and an optional sequence summary
  typedef struct packed {
    logic                     tok_valid;
    logic [IdW-1:0]           tok_id;
    logic signed [ScoreW-1:0] tok_score;
    logic                     sum_valid;
    logic signed [SumW-1:0]   score_total;
    logic [TallyW-1:0]        tally;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/ctcgd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module ctcgd_front import ctcgd_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [ScoreW-1:0] class_score_i,
  input  wire logic                     row_end_i,
  input  wire logic                     sequence_end_i,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [IdW-1:0]           cfg_data_i,
  input  wire logic                     q_full_i,
  output logic                          q_push_o,
  output cmd_t                          q_cmd_o
);

  localparam logic [IdW-1:0]    ColLim   = IdW'(ColLimit);
  localparam logic [TallyW-1:0] TallyLim = TallyW'(TallyLimit);

  logic [IdW-1:0]           dict_q, dict_d;
  logic signed [ScoreW-1:0] best_q, best_d;
  logic [IdW-1:0]           bidx_q, bidx_d;
  logic [IdW-1:0]           col_q, col_d;
  logic [IdW-1:0]           prev_q, prev_d;
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic [TallyW-1:0]        tally_q, tally_d;

  logic                     accept;
  logic                     row_done;
  logic                     greater;
  logic signed [ScoreW-1:0] new_best;
  logic [IdW-1:0]           new_idx;
  logic [IdW-1:0]           tok_id;
  logic                     tok_ok;
  logic                     count_ok;
  logic signed [SumW-1:0]   sum_next;
  logic [TallyW-1:0]        tally_next;

  assign in_stall_o  = q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !q_full_i;
  assign row_done    = row_end_i || sequence_end_i;

  // Running maximum; strict compare keeps the first column on a tie
  assign greater  = class_score_i > best_q;
  assign new_best = greater ? class_score_i : best_q;
  assign new_idx  = greater ? col_q : bidx_q;

  // Classify the row: drop repeats, blanks and ids outside the dictionary
  assign tok_id   = new_idx - IdW'(1);
  assign tok_ok   = row_done && (new_idx != prev_q) && (new_idx != '0) && (tok_id < dict_q);
  assign count_ok = tok_ok && (tally_q < TallyLim);

  assign sum_next   = count_ok ? (sum_q + {{(SumW-ScoreW){new_best[ScoreW-1]}}, new_best})
                               : sum_q;
  assign tally_next = count_ok ? (tally_q + TallyW'(1)) : tally_q;

  // Build the queue command
  always_comb begin
    q_push_o            = accept && (tok_ok || sequence_end_i);
    q_cmd_o.tok_valid   = tok_ok;
    q_cmd_o.tok_id      = tok_id;
    q_cmd_o.tok_score   = new_best;
    q_cmd_o.sum_valid   = sequence_end_i;
    q_cmd_o.score_total = sum_next;
    q_cmd_o.tally       = tally_next;
  end

  // Next state of the row and sequence trackers
  always_comb begin
    dict_d  = cfg_valid_i ? cfg_data_i : dict_q;
    best_d  = best_q;
    bidx_d  = bidx_q;
    col_d   = col_q;
    prev_d  = prev_q;
    sum_d   = sum_q;
    tally_d = tally_q;
    if (accept) begin
      if (row_done) begin
        best_d = SCORE_MIN;
        bidx_d = '0;
        col_d  = '0;
        if (new_idx != prev_q) begin
          prev_d = new_idx;
        end
      end else begin
        best_d = new_best;
        bidx_d = new_idx;
        col_d  = (col_q < ColLim) ? (col_q + IdW'(1)) : col_q;
      end
      sum_d   = sum_next;
      tally_d = tally_next;
      if (sequence_end_i) begin
        prev_d  = '0;
        sum_d   = '0;
        tally_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_q  <= '1;
      best_q  <= SCORE_MIN;
      bidx_q  <= '0;
      col_q   <= '0;
      prev_q  <= '0;
      sum_q   <= '0;
      tally_q <= '0;
    end else begin
      dict_q  <= dict_d;
      best_q  <= best_d;
      bidx_q  <= bidx_d;
      col_q   <= col_d;
      prev_q  <= prev_d;
      sum_q   <= sum_d;
      tally_q <= tally_d;
    end
  end

endmodule
`default_nettype wire

[rtl/ctcgd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module ctcgd_fifo import ctcgd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? (wr_ptr_q + PtrW'(1)) : wr_ptr_q;
    rd_ptr_d = pop_i ? (rd_ptr_q + PtrW'(1)) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command popped from an empty queue");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_o && empty_o))
    else $error("queue flagged full and empty at once");

endmodule
`default_nettype wire

[rtl/ctcgd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module ctcgd_back import ctcgd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire cmd_t               q_cmd_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    result_kind_o,
  output logic [IdW-1:0]          token_id_o,
  output logic signed [ScoreW-1:0] token_score_o,
  output logic signed [ScoreW-1:0] average_confidence_o,
  output logic [TallyW-1:0]       accepted_count_o,
  output logic                    last_o
);

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  cmd_t        div_src;

  // Output register
  logic                     out_valid_q;
  result_kind_e             out_kind_q;
  logic [IdW-1:0]           out_id_q;
  logic signed [ScoreW-1:0] out_score_q;
  logic signed [ScoreW-1:0] out_avg_q;
  logic [TallyW-1:0]        out_count_q;
  logic                     out_last_q;
  logic                     out_free;

  // Restoring divider
  logic [SumW-1:0]    quo_q;
  logic [TallyW-1:0]  rem_q;
  logic [TallyW-1:0]  dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               neg_q;
  logic               zero_q;
  logic [TallyW:0]    trial;
  logic               fits;
  logic [SumW-1:0]    quo_signed;
  logic signed [ScoreW-1:0] avg;

  logic load_tok, load_sum, div_start, div_step;

  assign out_free = !out_valid_q || !out_stall_i;
  assign div_src  = q_pop_o ? q_cmd_i : cmd_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = q_cmd_i.tok_valid ? BK_TOKEN : BK_DIV;
        end
      end
      BK_TOKEN: begin
        if (out_free) begin
          state_d = cmd_q.sum_valid ? BK_DIV : BK_IDLE;
        end
      end
      BK_DIV: begin
        if (cnt_q == '0) begin
          state_d = BK_SUMMARY;
        end
      end
      BK_SUMMARY: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    q_pop_o   = 1'b0;
    load_tok  = 1'b0;
    load_sum  = 1'b0;
    div_start = 1'b0;
    div_step  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        q_pop_o   = !q_empty_i;
        div_start = !q_empty_i && !q_cmd_i.tok_valid;
      end
      BK_TOKEN: begin
        load_tok  = out_free;
        div_start = out_free && cmd_q.sum_valid;
      end
      BK_DIV: begin
        div_step = 1'b1;
      end
      BK_SUMMARY: begin
        load_sum = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the popped command
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
    end
  end

  // One quotient bit per cycle on the magnitude of the sum
  assign trial = {rem_q, quo_q[SumW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (div_start) begin
      cnt_q <= DivCntW'(DivSteps - 1);
    end else if (div_step && (cnt_q != '0)) begin
      cnt_q <= cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      quo_q  <= div_src.score_total[SumW-1] ? (-div_src.score_total) : div_src.score_total;
      rem_q  <= '0;
      dvs_q  <= div_src.tally;
      neg_q  <= div_src.score_total[SumW-1];
      zero_q <= (div_src.tally == '0);
    end else if (div_step) begin
      quo_q <= {quo_q[SumW-2:0], fits};
      rem_q <= fits ? TallyW'(trial - {1'b0, dvs_q}) : trial[TallyW-1:0];
    end
  end

  // Truncate toward zero; no tokens gives zero
  assign quo_signed = neg_q ? (-quo_q) : quo_q;
  assign avg        = zero_q ? '0 : quo_signed[ScoreW-1:0];

  // Output register; accepts a new result while the old one leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_tok || load_sum) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_tok) begin
      out_kind_q  <= KIND_TOKEN;
      out_id_q    <= cmd_q.tok_id;
      out_score_q <= cmd_q.tok_score;
      out_avg_q   <= '0;
      out_count_q <= '0;
      out_last_q  <= !cmd_q.sum_valid;
    end else if (load_sum) begin
      out_kind_q  <= KIND_SUMMARY;
      out_id_q    <= '0;
      out_score_q <= '0;
      out_avg_q   <= avg;
      out_count_q <= cmd_q.tally;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign result_kind_o        = out_kind_q;
  assign token_id_o           = out_id_q;
  assign token_score_o        = out_score_q;
  assign average_confidence_o = out_avg_q;
  assign accepted_count_o     = out_count_q;
  assign last_o               = out_last_q;

  a_summary_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KIND_SUMMARY)) |-> out_last_q)
    else $error("summary result without last");

  a_token_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KIND_TOKEN)) |-> ((out_avg_q == '0) && (out_count_q == '0)))
    else $error("token result carries summary fields");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BK_DIV) && (cnt_q == '0)) |=> (state_q == BK_SUMMARY))
    else $error("division did not finish into summary");

endmodule
`default_nettype wire

[rtl/ctc_greedy_token_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// CTC greedy token decoder.
// Input channel: one signed Q4.12 class score per transaction (in_valid_i,
// in_stall_o), with row_end_i on the last score of a time step and
// sequence_end_i on the last score of the sequence. Scores are taken one per
// cycle while the four-entry command queue has room.
// Output channel (out_valid_o, out_stall_i): token results and an
// end-of-sequence summary; last_o marks the final result of an input item.
// A token goes from its row-end score through the command queue and the
// back end's command register into the output register. A summary first
// needs a bit-serial division in the back end; the divider sets the summary
// rate, and the queue lets scores keep flowing meanwhile until it fills.
// Configuration: one write channel (cfg_valid_i, cfg_ready_o, cfg_data_i)
// sets the dictionary size; write it only while the decoder is idle.
// Reset clears the row and sequence state, empties the queue and sets the
// dictionary size to 32767. When the receiver stalls, the result is held in
// the output register, the queue fills and then in_stall_o rises.
module ctc_greedy_token_decoder import ctcgd_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [ScoreW-1:0] class_score_i,
  input  wire logic                     row_end_i,
  input  wire logic                     sequence_end_i,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [IdW-1:0]           cfg_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          result_kind_o,
  output logic [IdW-1:0]                token_id_o,
  output logic signed [ScoreW-1:0]      token_score_o,
  output logic signed [ScoreW-1:0]      average_confidence_o,
  output logic [TallyW-1:0]             accepted_count_o,
  output logic                          last_o
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_wr_cmd, q_rd_cmd;

  ctcgd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .class_score_i  (class_score_i),
    .row_end_i      (row_end_i),
    .sequence_end_i (sequence_end_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (q_wr_cmd)
  );

  ctcgd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_cmd),
    .pop_i   (q_pop),
    .data_o  (q_rd_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ctcgd_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_empty_i            (q_empty),
    .q_cmd_i              (q_rd_cmd),
    .q_pop_o              (q_pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .result_kind_o        (result_kind_o),
    .token_id_o           (token_id_o),
    .token_score_o        (token_score_o),
    .average_confidence_o (average_confidence_o),
    .accepted_count_o     (accepted_count_o),
    .last_o               (last_o)
  );

endmodule
`default_nettype wire

[test/ctc_greedy_token_decoder_tb.sv]
`timescale 1ns / 1ps
module ctc_greedy_token_decoder_tb;
  import ctcgd_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic signed [ScoreW-1:0] SCORE_MAX = 16'sh7FFF;

  typedef struct {
    result_kind_e             kind;
    logic [IdW-1:0]           id;
    logic signed [ScoreW-1:0] score;
    logic signed [ScoreW-1:0] avg;
    logic [TallyW-1:0]        count;
    logic                     last;
  } decode_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [ScoreW-1:0] class_score = '0;
  logic                     row_end = 1'b0;
  logic                     seq_end = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IdW-1:0]           cfg_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     result_kind;
  logic [IdW-1:0]           token_id;
  logic signed [ScoreW-1:0] token_score;
  logic signed [ScoreW-1:0] average_confidence;
  logic [TallyW-1:0]        accepted_count;
  logic                     last;

  // Decoder state as predicted from the accepted scores
  logic [IdW-1:0]           dictionary_limit;
  logic signed [ScoreW-1:0] row_peak;
  logic [IdW-1:0]           best_column;
  logic [IdW-1:0]           column;
  logic [IdW-1:0]           previous_argmax;
  logic signed [SumW-1:0]   confidence_sum;
  logic [TallyW-1:0]        tally;

  decode_result_t pending_results[$];
  bit idle_en = 1'b1;
  int mismatch_count = 0;
  int scores_sent = 0;
  int tokens_checked = 0;
  int summaries_checked = 0;
  int quiet_cycles = 0;

  ctc_greedy_token_decoder uut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .class_score_i        (class_score),
    .row_end_i            (row_end),
    .sequence_end_i       (seq_end),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_data_i           (cfg_data),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .result_kind_o        (result_kind),
    .token_id_o           (token_id),
    .token_score_o        (token_score),
    .average_confidence_o (average_confidence),
    .accepted_count_o     (accepted_count),
    .last_o               (last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (mismatch_count < 50) begin
      $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
    end
    mismatch_count++;
  endtask

  task automatic clear_row_state();
    row_peak    = SCORE_MIN;
    best_column = '0;
    column      = '0;
  endtask

  task automatic clear_sequence_state();
    clear_row_state();
    previous_argmax = '0;
    confidence_sum  = '0;
    tally           = '0;
  endtask

  // Advance the greedy decode by one score and queue the results it causes
  task automatic decode_score(input logic signed [ScoreW-1:0] score, input logic re,
                              input logic se);
    decode_result_t token;
    decode_result_t summary;
    logic [IdW-1:0] argmax;
    int sum_now;
    int tally_now;
    if (score > row_peak) begin
      row_peak    = score;
      best_column = column;
    end
    if (column < ColLimit) column++;

    if (re || se) begin
      argmax = best_column;
      if (argmax != previous_argmax) begin
        previous_argmax = argmax;
        // blank class and ids beyond the dictionary give no token
        if (argmax != '0 && (argmax - 1'b1) < dictionary_limit) begin
          token.kind  = KIND_TOKEN;
          token.id    = argmax - 1'b1;
          token.score = row_peak;
          token.avg   = '0;
          token.count = '0;
          token.last  = !se;
          pending_results.insert(pending_results.size(), token);
          if (tally < TallyLimit) begin
            confidence_sum += row_peak;
            tally++;
          end
        end
      end
      clear_row_state();
    end

    if (se) begin
      summary.kind  = KIND_SUMMARY;
      summary.id    = '0;
      summary.score = '0;
      summary.avg   = '0;
      if (tally != '0) begin
        sum_now     = confidence_sum;
        tally_now   = tally;
        summary.avg = ScoreW'(sum_now / tally_now);
      end
      summary.count = tally;
      summary.last  = 1'b1;
      pending_results.insert(pending_results.size(), summary);
      clear_sequence_state();
    end
  endtask

  // Offer one score, hold it until the decoder takes it
  task automatic send_score(input logic signed [ScoreW-1:0] score, input logic re,
                            input logic se);
    @(negedge clk);
    while (idle_en && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    class_score = score;
    row_end     = re;
    seq_end     = se;
    do @(posedge clk); while (in_stall);
    decode_score(score, re, se);
    scores_sent++;
  endtask

  // Stop sending, let every expected result arrive and the divider settle
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dictionary_size(input logic [IdW-1:0] size);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = size;
    do @(posedge clk); while (!cfg_ready);
    dictionary_limit = size;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Blank rows, ties, repeats, score extremes and truncated averages
  task automatic test_directed_rows();
    send_score(-32768, 1'b0, 1'b0);
    send_score(-32768, 1'b0, 1'b0);
    send_score(-32768, 1'b1, 1'b0);
    send_score(-32768, 1'b0, 1'b0);
    send_score(SCORE_MAX, 1'b0, 1'b0);
    send_score(SCORE_MAX, 1'b1, 1'b0);
    send_score(0, 1'b0, 1'b0);
    send_score(5, 1'b1, 1'b0);
    send_score(100, 1'b0, 1'b0);
    send_score(-1, 1'b1, 1'b0);
    send_score(-5, 1'b0, 1'b0);
    send_score(-3, 1'b0, 1'b0);
    send_score(-4, 1'b1, 1'b0);
    send_score(-9, 1'b0, 1'b0);
    send_score(-8, 1'b0, 1'b0);
    send_score(-7, 1'b0, 1'b1);
    // sequence with no token at all
    send_score(1234, 1'b1, 1'b1);
    // negative average truncates towards zero
    send_score(-32768, 1'b0, 1'b0);
    send_score(-3, 1'b1, 1'b0);
    send_score(-1, 1'b0, 1'b0);
    send_score(-2, 1'b0, 1'b0);
    send_score(-4, 1'b1, 1'b0);
    send_score(-32768, 1'b0, 1'b0);
    send_score(-32768, 1'b0, 1'b0);
    send_score(-4, 1'b1, 1'b1);
  endtask

  // Dictionary of no, one and two entries, then back to the full size
  task automatic test_dictionary_size();
    logic [IdW-1:0] sizes[3] = '{15'd0, 15'd1, 15'd2};
    foreach (sizes[i]) begin
      write_dictionary_size(sizes[i]);
      send_score(0, 1'b0, 1'b0);
      send_score(10, 1'b1, 1'b0);
      send_score(10, 1'b0, 1'b0);
      send_score(0, 1'b0, 1'b0);
      send_score(20, 1'b0, 1'b1);
    end
    write_dictionary_size(15'd32767);
  endtask

  // Random sequences of short rows over several dictionary sizes
  task automatic test_random_sequences();
    logic [IdW-1:0] sizes[4];
    logic signed [ScoreW-1:0] score;
    int row_count;
    int row_len;
    int sent;
    int pick;
    bit row_done;
    bit seq_done;
    sizes = '{15'd32767, 15'($urandom_range(1, 8)), 15'($urandom), 15'd3};
    for (int phase = 0; phase < 4; phase++) begin
      write_dictionary_size(sizes[phase]);
      idle_en = (phase != 1);
      sent = 0;
      while (sent < 250) begin
        row_count = $urandom_range(1, 10);
        for (int r = 0; r < row_count; r++) begin
          row_len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
          for (int c = 0; c < row_len; c++) begin
            pick = $urandom_range(99);
            if (pick < 70) score = ScoreW'($urandom);
            else if (pick < 85) score = SCORE_MIN;
            else begin
              case ($urandom_range(3))
                0: score = 0;
                1: score = SCORE_MAX;
                2: score = 1;
                default: score = -1;
              endcase
            end
            row_done = (c == row_len - 1);
            seq_done = row_done && (r == row_count - 1);
            // the sequence end may close the row on its own
            send_score(score, row_done && !(seq_done && $urandom_range(1)), seq_done);
            sent++;
          end
        end
      end
    end
    idle_en = 1'b1;
  endtask

  // Drive the result stall at random
  always @(negedge clk) begin
    out_stall = idle_en && ($urandom_range(99) < 30);
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    decode_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", result_kind, -1);
      end else begin
        want = pending_results.pop_front();
        if (result_kind !== want.kind) report_mismatch("result_kind", result_kind, want.kind);
        if (token_id !== want.id) report_mismatch("token_id", token_id, want.id);
        if (token_score !== want.score) report_mismatch("token_score", token_score, want.score);
        if (average_confidence !== want.avg)
          report_mismatch("average_confidence", average_confidence, want.avg);
        if (accepted_count !== want.count)
          report_mismatch("accepted_count", accepted_count, want.count);
        if (last !== want.last) report_mismatch("last", last, want.last);
        if (want.kind == KIND_TOKEN) tokens_checked++;
        else summaries_checked++;
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
          $display("FAIL ctc_greedy_token_decoder");
          $finish;
        end
      end
    end
  end

  initial begin
    dictionary_limit = 15'd32767;
    clear_sequence_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_rows();
    test_dictionary_size();
    test_random_sequences();
    drain_results();

    $display("sent %0d scores: directed rows, dictionary limits, random sequences",
             scores_sent);
    $display("checked %0d tokens and %0d summaries, %0d mismatches",
             tokens_checked, summaries_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS ctc_greedy_token_decoder");
    end else begin
      $display("FAIL ctc_greedy_token_decoder");
    end
    $finish;
  end

endmodule
